>>> hdl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared constants, types and helpers for the set associative tag model.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int MAX_SETS_DEF  = 256;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 48;

  localparam int CFG_ADDR_W = 4;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_BITS = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_INDEX_BITS  = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] REG_WAYS        = 4'h8;

  // Access as classified by the front stage.
  typedef struct packed {
    logic [63:0] tag;
    logic [11:0] set;
    logic        wr;
  } sacf_req_t;

  // Result item.
  typedef struct packed {
    logic        hit;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] read_total;
    logic [31:0] write_total;
  } sacf_res_t;

endpackage

>>> hdl/sacf_front.sv
// ----------------------------------------------------------------------------
// sacf_front
// Splits an accepted address into set and tag and hands it to a small queue.
// ----------------------------------------------------------------------------
module sacf_front #(
  parameter int MAX_SETS  = 256,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic                 wr,
  input  logic [4:0]           offset_bits,
  input  logic [3:0]           index_bits,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sacf_pkg::sacf_req_t  q_data
);
  import sacf_pkg::*;

  localparam int MIB = $clog2(MAX_SETS + 1) - 1;
  localparam int QD  = 2;

  logic [63:0] addr_ext, block, tag, set_mask;
  logic [5:0]  off;
  logic [3:0]  ib;
  sacf_req_t   cls;
  sacf_req_t   q_mem [QD];
  logic        wp, rp;
  logic [1:0]  cnt;

  // Saturate shift amounts and split the address.
  always_comb begin
    addr_ext = 64'(addr);
    off = (32'(offset_bits) > ADDR_BITS) ? 6'(ADDR_BITS) : {1'b0, offset_bits};
    ib  = (32'(index_bits) > MIB) ? 4'(MIB) : index_bits;
    block = addr_ext >> off;
    set_mask = (64'd1 << ib) - 64'd1;
    cls.set = 12'(block & set_mask);
    tag = block >> ib;
    cls.tag = tag;
    cls.wr  = wr;
  end

  assign in_ready = (cnt != 2'(QD));
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = q_mem[rp];

  // Two entry queue toward the back stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q_mem[wp] <= cls;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

endmodule

>>> hdl/sacf_back.sv
// ----------------------------------------------------------------------------
// sacf_back
// Looks up one set, applies FIFO replacement and updates the counters.
// ----------------------------------------------------------------------------
module sacf_back #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  sacf_pkg::sacf_req_t q_data,
  input  logic [3:0]          ways_in_use,
  output logic                out_valid,
  input  logic                out_ready,
  output sacf_pkg::sacf_res_t out_data
);
  import sacf_pkg::*;

  localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FW = $clog2(MAX_WAYS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_OUT   = 4'b1000
  } st_t;

  st_t st;
  // One row per set holds the tags of all its ways.
  logic [MAX_WAYS-1:0][63:0] tag_mem [MAX_SETS];
  logic [FW-1:0] fill_mem [MAX_SETS];
  logic [WW-1:0] old_mem [MAX_SETS];
  logic [MAX_SETS-1:0] set_vld;
  logic [MAX_WAYS-1:0][63:0] rd_tag;
  logic [MAX_WAYS-1:0][63:0] row_nx;
  logic [FW-1:0] fill_rd;
  logic [WW-1:0] old_rd;
  sacf_req_t req;
  logic [SW-1:0] set;
  logic [FW-1:0] ways, filled;
  logic [MAX_WAYS-1:0] match;
  logic hit_now;
  logic [WW-1:0] vic, vic_nx, slot;
  logic [31:0] hits, misses, reads, writes;

  assign q_ready = (st == ST_IDLE);
  assign out_valid = (st == ST_OUT);
  assign set = SW'(req.set);

  // Effective way count and fill level.
  always_comb begin
    if (ways_in_use == 4'd0) ways = FW'(1);
    else if (32'(ways_in_use) > MAX_WAYS) ways = FW'(MAX_WAYS);
    else ways = FW'(ways_in_use);
    filled = set_vld[set] ? fill_rd : '0;
    if (filled > ways) filled = ways;
    for (int w = 0; w < MAX_WAYS; w++)
      match[w] = (FW'(w) < filled) && (rd_tag[w] == req.tag);
    hit_now = |match;
    vic = set_vld[set] ? old_rd : '0;
    if (FW'(vic) >= ways) vic = '0;
    vic_nx = (FW'(vic) + FW'(1) >= ways) ? '0 : WW'(FW'(vic) + FW'(1));
    // A miss fills the next free way, or else the oldest one.
    slot = (filled < ways) ? WW'(filled) : vic;
    row_nx = rd_tag;
    row_nx[slot] = req.tag;
  end

  // Set read, then compare and write back.
  always_ff @(posedge clk) begin
    if (st == ST_READ) begin
      rd_tag  <= tag_mem[set];
      fill_rd <= fill_mem[set];
      old_rd  <= old_mem[set];
    end
    if (st == ST_IDLE && q_valid) req <= q_data;
    if (st == ST_CHECK && !hit_now) begin
      tag_mem[set] <= row_nx;
      if (filled < ways) begin
        fill_mem[set] <= filled + FW'(1);
        old_mem[set]  <= vic;
      end else begin
        old_mem[set]  <= vic_nx;
      end
    end
    if (st == ST_CHECK) begin
      out_data.hit <= hit_now;
      out_data.mem_read <= !hit_now;
      out_data.mem_write <= req.wr;
      out_data.hit_total <= hits + 32'(hit_now);
      out_data.miss_total <= misses + 32'(!hit_now);
      out_data.read_total <= reads + 32'(!hit_now);
      out_data.write_total <= writes + 32'(req.wr);
    end
    if (rst) begin
      st <= ST_IDLE;
      set_vld <= '0;
      hits <= '0; misses <= '0; reads <= '0; writes <= '0;
    end else begin
      unique case (st)
        ST_IDLE:  if (q_valid) st <= ST_READ;
        ST_READ:  st <= ST_CHECK;
        ST_CHECK: begin
          st <= ST_OUT;
          if (!hit_now) set_vld[set] <= 1'b1;
          hits <= hits + 32'(hit_now);
          misses <= misses + 32'(!hit_now);
          reads <= reads + 32'(!hit_now);
          writes <= writes + 32'(req.wr);
        end
        ST_OUT:   if (out_ready) st <= ST_IDLE;
        default:  st <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/set_assoc_cache_fifo_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_sim
// Set associative cache tag model with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// Accesses enter on the s_axis channel (address and write flag) and each
// gives one result on m_axis: hit, memory read, memory write and four
// wrapping 32-bit running counts. The user must write the registers over
// the APB port only while the block is idle; the block does not enforce it.
// A front stage splits the address and pushes it into a two entry queue; the
// back stage reads one set row per access, compares all ways in parallel and
// writes the row back on a miss. For each access the back stage takes it
// from the queue, reads the set, compares and writes back, then gives the
// result; bound by the single set memory read-modify-write, it takes no new
// access from the queue until its result has been transferred.
// Reset clears the counters, registers and per-set valid bits, so all sets
// read as empty at once; no clearing pass is needed.
// When m_axis stalls the result is held and the queue keeps taking up to two
// more inputs.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_sim #(
  parameter int MAX_SETS  = sacf_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = sacf_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = sacf_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [((ADDR_BITS+7)/8)*8-1:0] s_axis_tdata, // access_address
  input  logic                         s_axis_tuser,   // is_write
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hit, mem_read, mem_write, hit_total, miss_total, read_total, write_total
  output logic [135:0]                 m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sacf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sacf_pkg::*;

  logic [4:0] offset_bits;
  logic [3:0] index_bits, ways_in_use;
  logic q_valid, q_ready;
  sacf_req_t q_data;
  sacf_res_t res;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= '0;
      index_bits  <= '0;
      ways_in_use <= 4'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_OFFSET_BITS: offset_bits <= pwdata[4:0];
        REG_INDEX_BITS:  index_bits  <= pwdata[3:0];
        REG_WAYS:        ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_OFFSET_BITS: prdata = 32'(offset_bits);
      REG_INDEX_BITS:  prdata = 32'(index_bits);
      REG_WAYS:        prdata = 32'(ways_in_use);
      default:         prdata = '0;
    endcase
  end

  sacf_front #(.MAX_SETS(MAX_SETS), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .addr(s_axis_tdata[ADDR_BITS-1:0]), .wr(s_axis_tuser),
    .offset_bits, .index_bits,
    .q_valid, .q_ready, .q_data
  );

  sacf_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .ways_in_use,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
  );

  assign m_axis_tdata = {5'd0, res.write_total, res.read_total, res.miss_total,
                         res.hit_total, res.mem_write, res.mem_read, res.hit};

  // A hit never asks for a memory read, and a miss always does.
  a_hit_no_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[1])) else $error("hit and read");

  // A stalled result keeps its counts.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");

  // A full queue never reports itself empty.
  a_queue: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid) else $error("queue full but empty");

endmodule
